>>> hw/rtl/jdz_pkg.sv
// ----------------------------------------------------------------------------
// jdz_pkg
// Shared types and constants for the joystick dead-zone scaler: sample and
// result words, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package jdz_pkg;

  // adc resolution and derived widths
  localparam int ADC_BITS   = 10;
  localparam int PROD_BITS  = ADC_BITS + 7;   // offset times the scale factor
  localparam int QUOT_BITS  = 7;              // quotient never exceeds the scale factor
  localparam int SCALE      = 99;
  localparam int TIME_BITS  = 32;
  localparam int TOUT_BITS  = 15;
  localparam int DEAD_BITS  = 8;
  localparam int POS_BITS   = 8;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic signed [POS_BITS-1:0] POS_FULL = 8'sd100;

  // reset values of the configuration registers
  localparam logic [ADC_BITS-1:0]  CENTER_RST  = ADC_BITS'(512);
  localparam logic [DEAD_BITS-1:0] DEAD_RST    = 8'd10;
  localparam logic [TOUT_BITS-1:0] TIMEOUT_RST = 15'd1000;

  // input word
  typedef struct packed {
    logic [ADC_BITS-1:0]  adc_a;
    logic [ADC_BITS-1:0]  adc_b;
    logic [TIME_BITS-1:0] now_ms;
  } sample_t;

  // output word
  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic                       active;
  } result_t;

  // register map, one register per 32-bit word
  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_DEAD_ZONE    = 3'd2,
    REG_X_INVERT     = 3'd3,
    REG_Y_INVERT     = 3'd4,
    REG_SWAP_AXES    = 3'd5,
    REG_IDLE_TIMEOUT = 3'd6
  } reg_index_t;

  // which side of the dead zone an axis falls on
  typedef enum logic [1:0] {
    SIDE_ZERO,
    SIDE_NEG,
    SIDE_POS
  } side_t;

  // per-item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_START,
    ST_WAIT,
    ST_FIN
  } state_t;

endpackage

>>> hw/rtl/jdz_serdiv.sv
// ----------------------------------------------------------------------------
// jdz_serdiv
// Bit-serial restoring divider: one dividend bit shifted in per cycle, one
// quotient bit out per cycle, narrow remainder compare.
// ----------------------------------------------------------------------------
module jdz_serdiv (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [jdz_pkg::PROD_BITS-1:0]   dividend,
  input  logic [jdz_pkg::ADC_BITS-1:0]    divisor,
  output logic [jdz_pkg::QUOT_BITS-1:0]   quotient,
  output logic                            done
);

  localparam int PW = jdz_pkg::PROD_BITS;
  localparam int DW = jdz_pkg::ADC_BITS;
  localparam int CW = $clog2(PW + 1);

  logic [PW-1:0] dq;      // dividend shifting out, quotient shifting in
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [CW-1:0] cnt;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   diff;

  // one restoring step
  always_comb begin
    trial = {rem, dq[PW-1]};
    fits  = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  // step counter and done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CW'(PW);
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (cnt != '0) begin
      dq  <= {dq[PW-2:0], fits};
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quotient = dq[jdz_pkg::QUOT_BITS-1:0];

endmodule

>>> hw/rtl/joystick_deadzone_scaler.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_scaler
// Centers, dead-zones and scales a pair of joystick adc samples to -100..100
// per axis and tracks an activity flag with an idle timeout.
// ----------------------------------------------------------------------------
// One word is taken at a time and a new word is accepted once the previous
// result has moved into the output register. The pace is set by a single
// bit-serial divider, shared by both axes, which runs once per axis after
// a setup step, before the result is captured. Registers sit at byte
// address 4*index and must be written only while no word is in flight;
// the block itself does not enforce this.
module joystick_deadzone_scaler (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  jdz_pkg::sample_t                     sample,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output jdz_pkg::result_t                     result,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [jdz_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [jdz_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [jdz_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int B  = jdz_pkg::ADC_BITS;
  localparam int PW = jdz_pkg::PROD_BITS;
  localparam int DB = jdz_pkg::DEAD_BITS;
  localparam int TB = jdz_pkg::TIME_BITS;
  localparam int OB = jdz_pkg::POS_BITS;

  // configuration registers
  logic [B-1:0]                    center_x;
  logic [B-1:0]                    center_y;
  logic [DB-1:0]                   dead_zone;
  logic                            x_invert;
  logic                            y_invert;
  logic                            swap_axes;
  logic [jdz_pkg::TOUT_BITS-1:0]   idle_timeout_ms;

  jdz_pkg::reg_index_t             reg_sel;
  logic                            cfg_write;

  // item state
  jdz_pkg::state_t                 state;
  jdz_pkg::state_t                 state_next;
  logic                            axis;
  logic [B-1:0]                    smp_x;
  logic [B-1:0]                    smp_y;
  logic [TB-1:0]                   now_q;
  logic [TB-1:0]                   last_move_ms;
  jdz_pkg::side_t                  side;
  logic [B-1:0]                    num;
  logic [B-1:0]                    den;
  logic signed [OB-1:0]            res_x;
  logic signed [OB-1:0]            res_y;

  // sequencer outputs
  logic                            take;
  logic                            div_start;
  logic                            load_out;

  // divider
  logic [PW-1:0]                   prod;
  logic [jdz_pkg::QUOT_BITS-1:0]   quot;
  logic                            div_done;

  // ---------------------------------------------------------------- registers
  assign pready    = 1'b1;
  assign reg_sel   = jdz_pkg::reg_index_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= jdz_pkg::CENTER_RST;
      center_y        <= jdz_pkg::CENTER_RST;
      dead_zone       <= jdz_pkg::DEAD_RST;
      x_invert        <= 1'b0;
      y_invert        <= 1'b0;
      swap_axes       <= 1'b0;
      idle_timeout_ms <= jdz_pkg::TIMEOUT_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        jdz_pkg::REG_CENTER_X:     center_x        <= pwdata[B-1:0];
        jdz_pkg::REG_CENTER_Y:     center_y        <= pwdata[B-1:0];
        jdz_pkg::REG_DEAD_ZONE:    dead_zone       <= pwdata[DB-1:0];
        jdz_pkg::REG_X_INVERT:     x_invert        <= pwdata[0];
        jdz_pkg::REG_Y_INVERT:     y_invert        <= pwdata[0];
        jdz_pkg::REG_SWAP_AXES:    swap_axes       <= pwdata[0];
        jdz_pkg::REG_IDLE_TIMEOUT: idle_timeout_ms <= pwdata[jdz_pkg::TOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (reg_sel)
      jdz_pkg::REG_CENTER_X:     prdata = 32'(center_x);
      jdz_pkg::REG_CENTER_Y:     prdata = 32'(center_y);
      jdz_pkg::REG_DEAD_ZONE:    prdata = 32'(dead_zone);
      jdz_pkg::REG_X_INVERT:     prdata = 32'(x_invert);
      jdz_pkg::REG_Y_INVERT:     prdata = 32'(y_invert);
      jdz_pkg::REG_SWAP_AXES:    prdata = 32'(swap_axes);
      jdz_pkg::REG_IDLE_TIMEOUT: prdata = 32'(idle_timeout_ms);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  assign sample_stall = (state != jdz_pkg::ST_IDLE);
  assign take         = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jdz_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      jdz_pkg::ST_IDLE: begin
        if (take) begin
          state_next = jdz_pkg::ST_PREP;
        end
      end
      jdz_pkg::ST_PREP: begin
        state_next = jdz_pkg::ST_START;
      end
      jdz_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = jdz_pkg::ST_WAIT;
      end
      jdz_pkg::ST_WAIT: begin
        if (div_done) begin
          state_next = axis ? jdz_pkg::ST_FIN : jdz_pkg::ST_PREP;
        end
      end
      jdz_pkg::ST_FIN: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = jdz_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jdz_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- axis setup
  logic [B-1:0]  cur_smp;
  logic [B-1:0]  cur_ctr;
  logic [B:0]    smp_dead;
  logic [B:0]    ctr_dead;
  logic [B:0]    dead_ext;
  logic [B:0]    neg_den;
  logic [B:0]    pos_num;
  logic [B:0]    pos_den;
  logic          is_neg;
  logic          is_pos;

  always_comb begin
    cur_smp  = axis ? smp_y : smp_x;
    cur_ctr  = axis ? center_y : center_x;
    dead_ext = (B + 1)'(dead_zone);
    smp_dead = {1'b0, cur_smp} + dead_ext;
    ctr_dead = {1'b0, cur_ctr} + dead_ext;
    is_neg   = smp_dead < {1'b0, cur_ctr};
    is_pos   = {1'b0, cur_smp} > ctr_dead;
    neg_den  = {1'b0, cur_ctr} - dead_ext;
    pos_num  = {1'b0, cur_smp} - ctr_dead;
    pos_den  = {1'b0, jdz_pkg::ADC_MAX} - ctr_dead;
  end

  // offset times the scale factor, as shifts and adds
  always_comb begin
    prod = (PW'(num) << 6) + (PW'(num) << 5) + (PW'(num) << 1) + PW'(num);
  end

  jdz_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .quotient (quot),
    .done     (div_done)
  );

  // map quotient onto the side's range and apply inversion
  logic signed [OB-1:0] mapped;
  logic signed [OB-1:0] axis_res;

  always_comb begin
    case (side)
      jdz_pkg::SIDE_NEG:  mapped = $signed(OB'(quot)) - jdz_pkg::POS_FULL;
      jdz_pkg::SIDE_POS:  mapped = $signed(OB'(quot)) + OB'(1);
      default:            mapped = '0;
    endcase
    axis_res = (axis ? y_invert : x_invert) ? -mapped : mapped;
  end

  // ---------------------------------------------------------------- datapath
  logic          moved;
  logic [TB-1:0] elapsed;
  logic          timed_out;

  always_comb begin
    moved     = (res_x != '0) || (res_y != '0);
    elapsed   = now_q - last_move_ms;
    timed_out = elapsed > TB'(idle_timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      smp_x <= swap_axes ? sample.adc_b : sample.adc_a;
      smp_y <= swap_axes ? sample.adc_a : sample.adc_b;
      now_q <= sample.now_ms;
    end
    if (state == jdz_pkg::ST_PREP) begin
      if (is_neg) begin
        side <= jdz_pkg::SIDE_NEG;
        num  <= cur_smp;
        den  <= neg_den[B-1:0];
      end else if (is_pos) begin
        side <= jdz_pkg::SIDE_POS;
        num  <= pos_num[B-1:0];
        den  <= pos_den[B-1:0];
      end else begin
        side <= jdz_pkg::SIDE_ZERO;
        num  <= '0;
        den  <= '0;
      end
    end
    if (state == jdz_pkg::ST_WAIT && div_done) begin
      if (axis) begin
        res_y <= axis_res;
      end else begin
        res_x <= axis_res;
      end
    end
    if (load_out) begin
      result.pos_x  <= res_x;
      result.pos_y  <= res_y;
      result.active <= moved || !timed_out;
    end
  end

  // axis select, last movement time, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      axis         <= 1'b0;
      last_move_ms <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        axis <= 1'b0;
      end else if (state == jdz_pkg::ST_WAIT && div_done) begin
        axis <= 1'b1;
      end
      if (load_out && moved) begin
        last_move_ms <= now_q;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> verif/joystick_deadzone_scaler_test.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_scaler_test
// Self-checking bench for the joystick dead-zone scaler. A queue-fed driver
// offers sample words in random bursts while the receiver stalls on a shifting
// pattern. Every accepted sample is run through a local scaler and activity
// tracker, and each result word is compared field by field with the oldest
// prediction. Settings change between phases through the register port.
// ----------------------------------------------------------------------------
module joystick_deadzone_scaler_test;

  localparam int SETTLE_CYCLES  = 60;    // beyond the block's latency
  localparam int LONG_HOLD      = 400;   // receiver hold-off length
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving
  localparam logic [2:0] UNMAPPED_REG = 3'd7;  // first index past the register map
  localparam int MAX_PRINTS     = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             sample_valid = 1'b0;
  logic             sample_stall;
  jdz_pkg::sample_t sample_word  = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  jdz_pkg::result_t result_word;

  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [jdz_pkg::CFG_ADDR_BITS-1:0] paddr   = '0;
  logic [jdz_pkg::CFG_DATA_BITS-1:0] pwdata  = '0;
  logic [jdz_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                              pready;

  joystick_deadzone_scaler uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow copy of the settings and the activity state
  logic [jdz_pkg::ADC_BITS-1:0]  cfg_center_x   = jdz_pkg::CENTER_RST;
  logic [jdz_pkg::ADC_BITS-1:0]  cfg_center_y   = jdz_pkg::CENTER_RST;
  logic [jdz_pkg::DEAD_BITS-1:0] cfg_dead_zone  = jdz_pkg::DEAD_RST;
  logic                          cfg_x_invert   = 1'b0;
  logic                          cfg_y_invert   = 1'b0;
  logic                          cfg_swap_axes  = 1'b0;
  logic [jdz_pkg::TOUT_BITS-1:0] cfg_idle_limit = jdz_pkg::TIMEOUT_RST;
  logic [jdz_pkg::TIME_BITS-1:0] last_move_ms   = '0;

  jdz_pkg::sample_t pending_samples[$];
  jdz_pkg::result_t expected_positions[$];
  int      mismatch_count = 0;
  logic [jdz_pkg::TIME_BITS-1:0] stim_clock_ms = '0;

  // handshake bookkeeping shared between the processes
  logic sample_fire      = 1'b0;
  bit   long_hold_needed = 1'b0;

  // center, dead-zone and scale one axis onto -100..100
  function automatic logic signed [jdz_pkg::POS_BITS-1:0] scale_axis(
    input logic [jdz_pkg::ADC_BITS-1:0] raw, input logic [jdz_pkg::ADC_BITS-1:0] ctr,
    input logic [jdz_pkg::DEAD_BITS-1:0] dz, input logic inv);
    int s, c, d, full, off, span, num, r;
    s = int'(raw);
    c = int'(ctr);
    d = int'(dz);
    full = int'(jdz_pkg::ADC_MAX);
    off = s - c;
    if (off < -d) begin
      span = c - d;
      num = off + c;
      if (span <= 0) begin
        r = -100;
      end else begin
        if (num < 0) num = 0;
        r = (num * jdz_pkg::SCALE) / span - 100;
        if (r < -100) r = -100;
        if (r > -1) r = -1;
      end
    end else if (off > d) begin
      span = full - c - d;
      num = off - d;
      if (span <= 0) begin
        r = 100;
      end else begin
        r = (num * jdz_pkg::SCALE) / span + 1;
        if (r > 100) r = 100;
        if (r < 1) r = 1;
      end
    end else begin
      r = 0;
    end
    if (inv) r = -r;
    return jdz_pkg::POS_BITS'(r);
  endfunction

  // expected result word for one sample, updates the activity state
  function automatic jdz_pkg::result_t predict_position(input jdz_pkg::sample_t s);
    jdz_pkg::result_t res;
    logic [jdz_pkg::ADC_BITS-1:0]  raw_x, raw_y;
    logic [jdz_pkg::TIME_BITS-1:0] elapsed;
    raw_x = cfg_swap_axes ? s.adc_b : s.adc_a;
    raw_y = cfg_swap_axes ? s.adc_a : s.adc_b;
    res.pos_x = scale_axis(raw_x, cfg_center_x, cfg_dead_zone, cfg_x_invert);
    res.pos_y = scale_axis(raw_y, cfg_center_y, cfg_dead_zone, cfg_y_invert);
    elapsed = s.now_ms - last_move_ms;
    if (res.pos_x != '0 || res.pos_y != '0) begin
      last_move_ms = s.now_ms;
      res.active = 1'b1;
    end else begin
      res.active = (elapsed > jdz_pkg::TIME_BITS'(cfg_idle_limit)) ? 1'b0 : 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [2:0] idx,
                           input logic [jdz_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      jdz_pkg::REG_CENTER_X:     cfg_center_x   = value[jdz_pkg::ADC_BITS-1:0];
      jdz_pkg::REG_CENTER_Y:     cfg_center_y   = value[jdz_pkg::ADC_BITS-1:0];
      jdz_pkg::REG_DEAD_ZONE:    cfg_dead_zone  = value[jdz_pkg::DEAD_BITS-1:0];
      jdz_pkg::REG_X_INVERT:     cfg_x_invert   = value[0];
      jdz_pkg::REG_Y_INVERT:     cfg_y_invert   = value[0];
      jdz_pkg::REG_SWAP_AXES:    cfg_swap_axes  = value[0];
      jdz_pkg::REG_IDLE_TIMEOUT: cfg_idle_limit = value[jdz_pkg::TOUT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_sample(input int a, input int b,
                              input logic [jdz_pkg::TIME_BITS-1:0] t);
    jdz_pkg::sample_t s;
    s.adc_a  = jdz_pkg::ADC_BITS'(a);
    s.adc_b  = jdz_pkg::ADC_BITS'(b);
    s.now_ms = t;
    pending_samples.push_back(s);
  endtask

  // stimulus pauses until every expected word is back, then lets the block settle
  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one axis sample: three in eight near its center, one in eight at the rails, rest anywhere
  function automatic int pick_axis(input logic [jdz_pkg::ADC_BITS-1:0] ctr);
    int c, d, v;
    c = int'(ctr);
    d = int'(cfg_dead_zone);
    case ($urandom_range(0, 7))
      0, 1, 2: v = c - d - 3 + int'($urandom_range(0, 2 * d + 6));
      3:       v = $urandom_range(0, 1) ? 0 : int'(jdz_pkg::ADC_MAX);
      default: v = $urandom_range(0, int'(jdz_pkg::ADC_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > int'(jdz_pkg::ADC_MAX)) v = int'(jdz_pkg::ADC_MAX);
    return v;
  endfunction

  // random sample on an advancing timeline, with jumps and timeout boundaries
  task automatic queue_random_sample();
    int step;
    case ($urandom_range(0, 15))
      0:       stim_clock_ms = $urandom();
      1, 2:    stim_clock_ms = stim_clock_ms + jdz_pkg::TIME_BITS'(cfg_idle_limit)
                               + $urandom_range(0, 1);
      default: begin
        step = $urandom_range(0, int'(cfg_idle_limit) / 3 + 3);
        stim_clock_ms = stim_clock_ms + step;
      end
    endcase
    queue_sample(pick_axis(cfg_swap_axes ? cfg_center_y : cfg_center_x),
                 pick_axis(cfg_swap_axes ? cfg_center_x : cfg_center_y), stim_clock_ms);
  endtask

  function automatic logic [jdz_pkg::CFG_DATA_BITS-1:0] pick_center();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return jdz_pkg::CFG_DATA_BITS'(jdz_pkg::ADC_MAX);
      2:       return $urandom();
      default: return $urandom_range(0, int'(jdz_pkg::ADC_MAX));
    endcase
  endfunction

  task automatic randomize_settings();
    logic [jdz_pkg::CFG_DATA_BITS-1:0] dz, tout;
    case ($urandom_range(0, 5))
      0:       dz = 0;
      1:       dz = 255;
      2:       dz = $urandom();
      default: dz = $urandom_range(0, 40);
    endcase
    case ($urandom_range(0, 5))
      0:       tout = 0;
      1:       tout = 32767;
      2:       tout = $urandom();
      default: tout = $urandom_range(0, 300);
    endcase
    write_reg(jdz_pkg::REG_CENTER_X, pick_center());
    write_reg(jdz_pkg::REG_CENTER_Y, pick_center());
    write_reg(jdz_pkg::REG_DEAD_ZONE, dz);
    write_reg(jdz_pkg::REG_X_INVERT, $urandom());
    write_reg(jdz_pkg::REG_Y_INVERT, $urandom());
    write_reg(jdz_pkg::REG_SWAP_AXES, $urandom());
    write_reg(jdz_pkg::REG_IDLE_TIMEOUT, tout);
  endtask

  // stimulus and phase sequencing
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words at reset settings: rails, dead-zone edges, timeout, time wrap
    queue_sample(512, 512, 32'd0);
    queue_sample(522, 502, 32'd10);
    queue_sample(523, 501, 32'd20);
    queue_sample(0, 1023, 32'd30);
    queue_sample(1023, 0, 32'd40);
    queue_sample(0, 0, 32'd50);
    queue_sample(1023, 1023, 32'd60);
    queue_sample(512, 512, 32'd1060);
    queue_sample(512, 512, 32'd1061);
    queue_sample(1022, 1, 32'd2000);
    queue_sample(682, 341, 32'hAAAA_5555);
    queue_sample(341, 682, 32'h5555_AAAA);
    queue_sample(600, 512, 32'hFFFF_FF00);
    queue_sample(512, 512, 32'hFFFF_FFFF);
    queue_sample(512, 512, 32'h0000_02E8);
    queue_sample(512, 512, 32'h0000_02E9);
    queue_sample(501, 523, 32'h0000_0300);
    queue_sample(502, 522, 32'h0000_0301);
    wait_drained();

    // every register at its ceiling through all-ones writes, plus an unmapped write
    write_reg(jdz_pkg::REG_CENTER_X, '1);
    write_reg(jdz_pkg::REG_CENTER_Y, '1);
    write_reg(jdz_pkg::REG_DEAD_ZONE, '1);
    write_reg(jdz_pkg::REG_X_INVERT, '1);
    write_reg(jdz_pkg::REG_Y_INVERT, '1);
    write_reg(jdz_pkg::REG_SWAP_AXES, '1);
    write_reg(jdz_pkg::REG_IDLE_TIMEOUT, '1);
    write_reg(UNMAPPED_REG, '0);
    stim_clock_ms = 32'hFFFF_F000;
    repeat (15) queue_random_sample();
    queue_sample(0, 0, stim_clock_ms + 1);
    queue_sample(1023, 1023, stim_clock_ms + 2);
    wait_drained();

    // every register at zero
    write_reg(jdz_pkg::REG_CENTER_X, '0);
    write_reg(jdz_pkg::REG_CENTER_Y, '0);
    write_reg(jdz_pkg::REG_DEAD_ZONE, '0);
    write_reg(jdz_pkg::REG_X_INVERT, '0);
    write_reg(jdz_pkg::REG_Y_INVERT, '0);
    write_reg(jdz_pkg::REG_SWAP_AXES, '0);
    write_reg(jdz_pkg::REG_IDLE_TIMEOUT, '0);
    repeat (15) queue_random_sample();
    queue_sample(0, 0, stim_clock_ms);
    queue_sample(0, 0, stim_clock_ms + 1);
    queue_sample(1023, 1023, stim_clock_ms + 2);
    wait_drained();

    // random settings and traffic, one long receiver hold-off in the first phase
    for (int phase = 0; phase < 6; phase++) begin
      randomize_settings();
      if (phase == 0) long_hold_needed = 1'b1;
      repeat (75) queue_random_sample();
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // sender: bursts of words with random gaps, holds a word until it is taken
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !sample_fire) begin
      // word not yet taken, keep it
    end else if (gap_left != 0) begin
      sample_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_samples.size() == 0) begin
      sample_valid <= 1'b0;
    end else begin
      sample_valid <= 1'b1;
      sample_word  <= pending_samples[0];
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  end

  // receiver: random stall pattern, redrawn whenever pattern_pos wraps, plus one long hold-off
  logic [15:0] stall_pattern = '0;
  int          pattern_pos   = 0;
  int          hold_left     = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (long_hold_needed) begin
      long_hold_needed = 1'b0;
      hold_left = LONG_HOLD - 1;
      result_stall <= 1'b1;
    end else begin
      if (pattern_pos == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '0;
          1:       stall_pattern = 16'($urandom());
          default: stall_pattern = 16'($urandom() & $urandom());
        endcase
      end
      result_stall <= stall_pattern[4'(pattern_pos % 16)];
      pattern_pos = (pattern_pos + 1) % 64;
    end
  end

  // monitor: check result words, predict accepted samples
  always @(posedge clk) begin : monitor
    jdz_pkg::result_t want;
    if (rst) begin
      sample_fire <= 1'b0;
    end else begin
      sample_fire <= sample_valid && !sample_stall;
      if (result_valid && !result_stall) begin
        if (expected_positions.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", result_word));
        end else begin
          want = expected_positions.pop_front();
          if (result_word.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x expected %0d got %0d",
                                      want.pos_x, result_word.pos_x));
          if (result_word.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y expected %0d got %0d",
                                      want.pos_y, result_word.pos_y));
          if (result_word.active !== want.active)
            report_mismatch($sformatf("active expected %0d got %0d",
                                      want.active, result_word.active));
        end
      end
      if (sample_valid && !sample_stall) begin
        expected_positions.push_back(predict_position(sample_word));
        void'(pending_samples.pop_front());
      end
    end
  end

  // watchdog on cycles with no word moving in either direction
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
